[src/jsif_pkg.sv]
// Shared types and constants for the JPEG second-image finder.
// Used by jsif_scan and jpeg_second_image_finder_core; no dependencies.
package jsif_pkg;

	localparam int SPLIT_W = 32;

	// marker bytes and code ranges
	localparam logic [7:0] MARK_FF  = 8'hFF;
	localparam logic [7:0] CODE_SOI = 8'hD8;
	localparam logic [7:0] CODE_EOI = 8'hD9;
	localparam logic [7:0] CODE_TEM = 8'h01;
	localparam logic [7:0] RST_LO   = 8'hD0;
	localparam logic [7:0] RST_HI   = 8'hD7;
	localparam logic [7:0] SEG1_LO  = 8'h02;
	localparam logic [7:0] SEG1_HI  = 8'hCF;
	localparam logic [7:0] SEG2_LO  = 8'hDA;
	localparam logic [7:0] SEG2_HI  = 8'hFD;
	localparam logic [15:0] MIN_LEN = 16'd2;

	typedef enum logic [2:0] {
		PS_SEEK   = 3'd0,
		PS_CODE   = 3'd1,
		PS_LEN_HI = 3'd2,
		PS_LEN_LO = 3'd3,
		PS_SKIP   = 3'd4
	} parse_t;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_AFTER = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		RSN_FOUND  = 3'd0,
		RSN_END    = 3'd1,
		RSN_NESTED = 3'd2,
		RSN_STRAY  = 3'd3,
		RSN_BADLEN = 3'd4
	} reason_t;

	typedef struct packed {
		phase_t      phase;
		parse_t      parse;
		logic [7:0]  len_hi;
		logic [15:0] skip;
	} scan_st_t;

	typedef struct packed {
		logic    hit;
		reason_t reason;
	} scan_res_t;

endpackage

[src/jpeg_second_image_finder_core.sv]
// JPEG second-image finder. The accepted byte is loaded into the input register, and
// its result then into the result register as the byte leaves the input register.
// Throughput: one byte per cycle; the input side stalls only while a result waits
// on a stalled output register.
// Reset: enable_q returns to 1, scan state and byte offset clear, both
// stages empty. A file's last byte rearms the scanner for the next file.
module jpeg_second_image_finder_core #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic [jsif_pkg::SPLIT_W-1:0] split_offset,
	output logic [2:0]               end_reason
);
	import jsif_pkg::*;

	localparam int EXT_W = (OFFSET_WIDTH > SPLIT_W) ? OFFSET_WIDTH : SPLIT_W;

	logic                    enable_q;
	logic                    valid_s1;
	logic [7:0]              data_s1;
	logic                    last_s1;
	scan_st_t                st_q;
	scan_st_t                st_nxt;
	scan_res_t               scan_res;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic                    finished_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [SPLIT_W-1:0]      split_q;
	reason_t                 reason_q;

	logic                    out_free;
	logic                    emit;
	logic                    advance;
	logic                    fire;
	logic                    accept;
	reason_t                 reason;
	logic [OFFSET_WIDTH-1:0] hit_pos;
	logic [EXT_W-1:0]        hit_ext;

	jsif_scan u_scan (
		.enable (enable_q),
		.data   (data_s1),
		.cur    (st_q),
		.nxt    (st_nxt),
		.res    (scan_res)
	);

	assign cfg_ready = 1'b1;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = valid_s1 && !finished_q && (scan_res.hit || last_s1);
	assign advance  = !emit || out_free;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign reason  = scan_res.hit ? scan_res.reason : RSN_END;
	assign hit_pos = pos_q - OFFSET_WIDTH'(1);	// offset of the FF before D8
	assign hit_ext = EXT_W'(hit_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// per-file scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '{phase: PH_NONE, parse: PS_SEEK, len_hi: '0, skip: '0};
			pos_q      <= '0;
			finished_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				st_q       <= '{phase: PH_NONE, parse: PS_SEEK, len_hi: '0, skip: '0};
				pos_q      <= '0;
				finished_q <= 1'b0;
			end else begin
				pos_q <= pos_q + OFFSET_WIDTH'(1);
				if (!finished_q) begin
					st_q <= st_nxt;
					if (emit) finished_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			found_q  <= (reason == RSN_FOUND);
			split_q  <= (reason == RSN_FOUND) ? hit_ext[SPLIT_W-1:0] : '0;
			reason_q <= reason;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign split_offset = split_q;
	assign end_reason   = reason_q;

`ifndef SYNTHESIS
	a_found_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (found_q == (reason_q == RSN_FOUND)))
		else $error("found flag disagrees with end reason");

	a_offset_zero_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (split_q == '0))
		else $error("split offset nonzero without a hit");

	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (!finished_q && pos_q == '0 && st_q.parse == PS_SEEK))
		else $error("last byte did not rearm the scanner");

	a_no_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && finished_q && !last_s1) |=> finished_q)
		else $error("finished flag dropped inside a file");
`endif

endmodule

[src/jsif_scan.sv]
// Marker walker: next scan state and early-stop result for one file byte.
// Purely combinational; types from jsif_pkg.
module jsif_scan (
	input  logic              enable,
	input  logic [7:0]        data,
	input  jsif_pkg::scan_st_t cur,
	output jsif_pkg::scan_st_t nxt,
	output jsif_pkg::scan_res_t res
);
	import jsif_pkg::*;

	logic [15:0] size;
	logic [15:0] skip_new;
	logic [15:0] skip_dec;

	assign size     = {cur.len_hi, data};
	assign skip_new = size - MIN_LEN;
	assign skip_dec = cur.skip - 16'd1;

	always_comb begin
		nxt        = cur;
		res.hit    = 1'b0;
		res.reason = RSN_END;
		if (enable) begin
			unique case (cur.parse)
				PS_CODE: begin
					nxt.parse = PS_SEEK;
					if (data == CODE_SOI) begin
						case (cur.phase)
							PH_NONE: nxt.phase = PH_FIRST;
							PH_AFTER: begin
								res.hit    = 1'b1;
								res.reason = RSN_FOUND;
							end
							PH_FIRST: begin
								res.hit    = 1'b1;
								res.reason = RSN_NESTED;
							end
							default: nxt.phase = PH_FIRST;
						endcase
					end else if (data == CODE_EOI) begin
						if (cur.phase == PH_FIRST) begin
							nxt.phase = PH_AFTER;
						end else begin
							res.hit    = 1'b1;
							res.reason = RSN_STRAY;
						end
					end else if (data == CODE_TEM || (data >= RST_LO && data <= RST_HI)) begin
						nxt.parse = PS_SEEK;	// standalone, nothing to skip
					end else if ((data >= SEG1_LO && data <= SEG1_HI) ||
							(data >= SEG2_LO && data <= SEG2_HI)) begin
						nxt.parse = PS_LEN_HI;
					end
				end
				PS_LEN_HI: begin
					nxt.len_hi = data;
					nxt.parse  = PS_LEN_LO;
				end
				PS_LEN_LO: begin
					if (size < MIN_LEN) begin
						res.hit    = 1'b1;
						res.reason = RSN_BADLEN;
					end else begin
						nxt.skip  = skip_new;
						nxt.parse = (skip_new != 16'd0) ? PS_SKIP : PS_SEEK;
					end
				end
				PS_SKIP: begin
					nxt.skip = skip_dec;
					if (skip_dec == 16'd0) nxt.parse = PS_SEEK;
				end
				default: nxt.parse = (data == MARK_FF) ? PS_CODE : PS_SEEK;
			endcase
		end
	end

endmodule

[bench/testbench.sv]
// Self-checking bench for jpeg_second_image_finder_core: a short directed table of
// marker sequences, then random JPEG-like files checked against a behavioral scanner.
// Depends on jsif_pkg and the core RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import jsif_pkg::*;

	typedef struct packed {
		logic                found;
		logic [SPLIT_W-1:0]  offset;
		reason_t             reason;
	} split_t;

	typedef struct packed {
		logic [7:0]          d;
		logic                l;
		logic                known;
		logic                found;
		logic [SPLIT_W-1:0]  offset;
		reason_t             reason;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          data_byte = 8'h00;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                found;
	logic [SPLIT_W-1:0]  split_offset;
	logic [2:0]          end_reason;

	jpeg_second_image_finder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.split_offset (split_offset),
		.end_reason   (end_reason)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scanner model state
	bit           scan_on = 1'b1;
	phase_t       pr_phase = PH_NONE;
	parse_t       pr_parse = PS_SEEK;
	logic [7:0]   pr_len_hi = 8'h00;
	logic [15:0]  pr_skip = 16'h0000;
	logic [31:0]  pr_pos = 32'h0;
	bit           pr_done = 1'b0;

	split_t       pending_splits[$];
	split_t       want;
	int           mismatches = 0;
	bit           idle_on = 1'b0;
	int unsigned  stall_left = 0;
	logic [7:0]   file_bytes[$];

	// smoke rows: found, stray EOI, nested SOI, bad length, FF FF D8 not a marker
	stim_row_t directed_rows [25] = '{
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_SOI, 1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{RST_LO,   1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_EOI, 1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_SOI, 1'b0, 1'b1, 1'b1, 32'd6, RSN_FOUND},
		'{8'h00,    1'b1, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_EOI, 1'b1, 1'b1, 1'b0, 32'd0, RSN_STRAY},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_SOI, 1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_SOI, 1'b1, 1'b1, 1'b0, 32'd0, RSN_NESTED},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_SOI, 1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{8'hC0,    1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{8'h00,    1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{8'h01,    1'b1, 1'b1, 1'b0, 32'd0, RSN_BADLEN},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{MARK_FF,  1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_SOI, 1'b0, 1'b0, 1'b0, 32'd0, RSN_END},
		'{CODE_TEM, 1'b1, 1'b1, 1'b0, 32'd0, RSN_END}
	};

	function automatic void clear_tracking();
		pr_phase = PH_NONE;
		pr_parse = PS_SEEK;
		pr_len_hi = 8'h00;
		pr_skip = 16'h0000;
		pr_pos = 32'h0;
		pr_done = 1'b0;
	endfunction

	// one byte through the marker walker; returns 1 when the scan ends here
	function automatic bit walk_marker(input logic [7:0] d, output reason_t why,
			output logic [31:0] hit);
		logic [15:0] seg_len;
		why = RSN_END;
		hit = '0;
		case (pr_parse)
		PS_CODE: begin
			pr_parse = PS_SEEK;
			if (d == CODE_SOI) begin
				if (pr_phase == PH_AFTER) begin
					hit = pr_pos - 32'd1;
					why = RSN_FOUND;
					return 1'b1;
				end else if (pr_phase == PH_FIRST) begin
					why = RSN_NESTED;
					return 1'b1;
				end
				pr_phase = PH_FIRST;
			end else if (d == CODE_EOI) begin
				if (pr_phase != PH_FIRST) begin
					why = RSN_STRAY;
					return 1'b1;
				end
				pr_phase = PH_AFTER;
			end else if ((d >= SEG1_LO && d <= SEG1_HI) || (d >= SEG2_LO && d <= SEG2_HI)) begin
				pr_parse = PS_LEN_HI;
			end
			// standalone and fill codes fall through with nothing to skip
		end
		PS_LEN_HI: begin
			pr_len_hi = d;
			pr_parse = PS_LEN_LO;
		end
		PS_LEN_LO: begin
			seg_len = {pr_len_hi, d};
			if (seg_len < MIN_LEN) begin
				why = RSN_BADLEN;
				return 1'b1;
			end
			pr_skip = seg_len - MIN_LEN;
			if (pr_skip != 0) pr_parse = PS_SKIP;
			else pr_parse = PS_SEEK;
		end
		PS_SKIP: begin
			pr_skip = pr_skip - 16'd1;
			if (pr_skip == 0) pr_parse = PS_SEEK;
		end
		default: begin
			if (d == MARK_FF) pr_parse = PS_CODE;
			else pr_parse = PS_SEEK;
		end
		endcase
		return 1'b0;
	endfunction

	function automatic bit predict_split(input logic [7:0] d, input logic l, output split_t res);
		reason_t     why;
		logic [31:0] hit;
		bit          ended;
		ended = 1'b0;
		why = RSN_END;
		hit = '0;
		res = '0;
		if (!pr_done) begin
			if (scan_on) ended = walk_marker(d, why, hit);
			if (!ended && l) begin
				ended = 1'b1;
				why = RSN_END;
			end
			if (ended) begin
				res.found = (why == RSN_FOUND);
				res.offset = (why == RSN_FOUND) ? hit : '0;
				res.reason = why;
				pr_done = 1'b1;
			end
		end
		pr_pos = pr_pos + 32'd1;
		if (l) clear_tracking();
		return ended;
	endfunction

	function automatic logic [7:0] seg_code();
		logic [7:0] c;
		c = 8'($urandom_range(SEG1_LO, SEG2_HI));
		if (c >= RST_LO && c <= CODE_EOI) c = c - 8'h10;
		return c;
	endfunction

	function automatic void add_piece(input bit broken);
		int unsigned n;
		logic [7:0]  b;
		case ($urandom_range(0, broken ? 10 : 7))
		0, 1, 2: begin
			file_bytes.push_back(MARK_FF);
			file_bytes.push_back(seg_code());
			n = $urandom_range(0, 6);
			if ($urandom_range(0, 15) == 0) begin
				// any length; the file usually ends inside the body
				file_bytes.push_back(8'($urandom));
				file_bytes.push_back(8'($urandom));
			end else begin
				file_bytes.push_back(8'h00);
				file_bytes.push_back(8'(n + 2));
			end
			repeat (n) file_bytes.push_back(8'($urandom));
		end
		3: begin
			file_bytes.push_back(MARK_FF);
			if ($urandom_range(0, 8) == 0) file_bytes.push_back(CODE_TEM);
			else file_bytes.push_back(8'($urandom_range(RST_LO, RST_HI)));
		end
		4: begin
			file_bytes.push_back(MARK_FF);
			case ($urandom_range(0, 2))
			0: file_bytes.push_back(8'h00);
			1: file_bytes.push_back(8'hFE);
			default: file_bytes.push_back(MARK_FF);
			endcase
		end
		5, 6, 7: begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom);
				file_bytes.push_back(b);
				if (b == MARK_FF) file_bytes.push_back(8'h00);
			end
		end
		8: begin
			file_bytes.push_back(MARK_FF);
			file_bytes.push_back(seg_code());
			file_bytes.push_back(8'h00);
			file_bytes.push_back(8'($urandom_range(0, 1)));
		end
		9: begin
			file_bytes.push_back(MARK_FF);
			file_bytes.push_back(CODE_SOI);
		end
		default: begin
			file_bytes.push_back(MARK_FF);
			file_bytes.push_back(CODE_EOI);
		end
		endcase
	endfunction

	// mostly well-formed files with random content; some noise, some broken
	function automatic void build_file();
		int unsigned kind;
		int unsigned cut;
		file_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 24))
				file_bytes.push_back(($urandom_range(0, 3) == 0) ? MARK_FF : 8'($urandom));
		end else begin
			if (kind != 1) begin
				file_bytes.push_back(MARK_FF);
				file_bytes.push_back(CODE_SOI);
			end
			repeat ($urandom_range(0, 4)) add_piece(kind == 2);
			file_bytes.push_back(MARK_FF);
			file_bytes.push_back(CODE_EOI);
			if ($urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(0, 2)) add_piece(kind == 2);
				file_bytes.push_back(MARK_FF);
				file_bytes.push_back(CODE_SOI);
				repeat ($urandom_range(0, 3)) add_piece(1'b0);
			end
		end
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut) void'(file_bytes.pop_back());
		end
	endfunction

	// in_valid stays high from one item to the next unless a gap is taken
	task automatic send_byte(input logic [7:0] d, input logic l, input bit known,
			input split_t known_res);
		split_t res;
		bit     got;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		got = predict_split(d, l, res);
		if (known) pending_splits.push_back(known_res);
		else if (got) pending_splits.push_back(res);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_splits.size() != 0) @(posedge clk);
		while (stall_left != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_enable(input bit en);
		cfg_valid <= 1'b1;
		cfg_data <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		scan_on = en;
	endtask

	task automatic run_phase(input bit en, input int unsigned items, input bit idling);
		int unsigned sent;
		if (!idling) idle_on = 1'b0;
		drain();
		write_enable(en);
		sent = 0;
		while (sent < items) begin
			idle_on = idling && ($urandom_range(0, 3) != 0);
			build_file();
			foreach (file_bytes[i])
				send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, '0);
			sent += file_bytes.size();
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_splits.size() == 0) begin
				$error("result item with nothing expected: found %0d offset %0d reason %0d",
					found, split_offset, end_reason);
				mismatches++;
			end else begin
				want = pending_splits.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					mismatches++;
				end
				if (split_offset !== want.offset) begin
					$error("split_offset: expected %0d, got %0d", want.offset, split_offset);
					mismatches++;
				end
				if (end_reason !== want.reason) begin
					$error("end_reason: expected %0d, got %0d", want.reason, end_reason);
					mismatches++;
				end
			end
		end
	end

	initial begin
		clear_tracking();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		foreach (directed_rows[i])
			send_byte(directed_rows[i].d, directed_rows[i].l, directed_rows[i].known,
				split_t'{directed_rows[i].found, directed_rows[i].offset,
				directed_rows[i].reason});
		run_phase(1'b1, 150, 1'b1);
		run_phase(1'b0, 60, 1'b1);
		run_phase(1'b1, 150, 1'b1);
		run_phase(1'b0, 60, 1'b1);
		run_phase(1'b1, 200, 1'b0);
		in_valid <= 1'b0;
		while (pending_splits.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
